FILE: design/polygon_area_centroid_defines.svh
// ---------------------------------------------------------------------------
// polygon_area_centroid assertion macros
// Concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef POLYGON_AREA_CENTROID_DEFINES_SVH
`define POLYGON_AREA_CENTROID_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pac assertion failed");
// next-cycle implication
`define PAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pac assertion failed");
`else
`define PAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/pac_pkg.sv
// ---------------------------------------------------------------------------
// pac_pkg
// Shared widths, defaults and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pac_pkg;

  localparam int COORD_W = 16;
  localparam int AREA_W  = 45;
  localparam int MOM_W   = 61;

  localparam int DEF_COORD_BITS   = 16;
  localparam int DEF_MAX_VERTICES = 4096;

  typedef struct packed {
    logic load_in;
    logic set_first;
    logic upd_prev;
    logic set_over;
    logic sel_close;
    logic mul_a;
    logic cross_sub;
    logic mul_b;
    logic acc_m;
    logic div_start;
    logic div_sel_y;
    logic out_load;
  } pac_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic last;
    logic div_done;
  } pac_status_t;

endpackage

FILE: design/pac_vertex_if.sv
// ---------------------------------------------------------------------------
// pac_vertex_if
// Vertex channel: valid/ready handshake with one polygon vertex per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pac_vertex_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pac_pkg::COORD_W-1:0]   vertex_x;
  logic signed [pac_pkg::COORD_W-1:0]   vertex_y;
  logic                                 last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

FILE: design/pac_result_if.sv
// ---------------------------------------------------------------------------
// pac_result_if
// Result channel: valid/ready handshake with one polygon result per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pac_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pac_pkg::AREA_W-1:0]    twice_area;
  logic signed [pac_pkg::COORD_W-1:0]   centroid_x;
  logic signed [pac_pkg::COORD_W-1:0]   centroid_y;
  logic                                 degenerate;
  logic                                 too_many;

  modport source (output valid, output twice_area, output centroid_x, output centroid_y,
                  output degenerate, output too_many, input ready);
  modport sink   (input valid, input twice_area, input centroid_x, input centroid_y,
                  input degenerate, input too_many, output ready);
endinterface

FILE: design/pac_divider.sv
// ---------------------------------------------------------------------------
// pac_divider
// Restoring divider: round(moment / (3 * area)) half away from zero,
// one quotient bit per cycle, saturated to the signed coordinate range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pac_divider #(
  parameter int COORD_BITS = pac_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic signed [pac_pkg::MOM_W-1:0]    num_i,
  input  logic signed [pac_pkg::AREA_W-1:0]   den_i,
  output logic                                done_o,
  output logic signed [pac_pkg::COORD_W-1:0]  quot_o
);

  localparam int CMP_W = pac_pkg::MOM_W + COORD_BITS + 3;
  localparam int QB    = COORD_BITS + 1;
  localparam int IT_W  = $clog2(COORD_BITS + 1);
  localparam logic [COORD_BITS-1:0] HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [4:0] {
    P_IDLE   = 5'b00001,
    P_ABS    = 5'b00010,
    P_TRIPLE = 5'b00100,
    P_SUM    = 5'b01000,
    P_ITER   = 5'b10000
  } pac_div_phase_t;

  pac_div_phase_t       phase_r, phase_nxt;
  logic [CMP_W-1:0]     rem_r, rem_nxt;
  logic [CMP_W-1:0]     dv_r, dv_nxt;
  logic [QB-1:0]        q_r, q_nxt;
  logic [IT_W-1:0]      it_r, it_nxt;
  logic                 neg_r, neg_nxt;
  logic                 done_r, done_nxt;

  logic [pac_pkg::MOM_W-1:0]  um;
  logic [pac_pkg::AREA_W-1:0] ua;
  logic [CMP_W:0]             diff;
  logic                       ge;
  logic                       sat;
  logic [COORD_BITS-1:0]      res;

  assign um   = num_i[pac_pkg::MOM_W-1] ? (~num_i + 1'b1) : num_i;
  assign ua   = den_i[pac_pkg::AREA_W-1] ? (~den_i + 1'b1) : den_i;
  assign diff = {1'b0, rem_r} - {1'b0, dv_r};
  assign ge   = !diff[CMP_W];

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    it_nxt    = it_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      P_IDLE: begin
        if (start_i) begin
          rem_nxt   = CMP_W'(um) << 1;
          dv_nxt    = CMP_W'(ua);
          neg_nxt   = num_i[pac_pkg::MOM_W-1] ^ den_i[pac_pkg::AREA_W-1];
          phase_nxt = P_TRIPLE;
        end
      end
      P_ABS: begin
        phase_nxt = P_TRIPLE;
      end
      P_TRIPLE: begin
        dv_nxt    = dv_r + (dv_r << 1);
        phase_nxt = P_SUM;
      end
      P_SUM: begin
        rem_nxt   = rem_r + dv_r;
        dv_nxt    = dv_r << (COORD_BITS + 1);
        it_nxt    = IT_W'(COORD_BITS);
        phase_nxt = P_ITER;
      end
      P_ITER: begin
        if (ge) begin
          rem_nxt = diff[CMP_W-1:0];
        end
        q_nxt  = {q_r[QB-2:0], ge};
        dv_nxt = dv_r >> 1;
        if (it_r == '0) begin
          done_nxt  = 1'b1;
          phase_nxt = P_IDLE;
        end else begin
          it_nxt = it_r - 1'b1;
        end
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    it_r  <= it_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      sat = q_r[QB-1] || (q_r[COORD_BITS-1] && (|q_r[COORD_BITS-2:0]));
      res = sat ? LO : (~q_r[COORD_BITS-1:0] + 1'b1);
    end else begin
      sat = q_r[QB-1] || q_r[COORD_BITS-1];
      res = sat ? HI : q_r[COORD_BITS-1:0];
    end
  end

  assign done_o = done_r;
  assign quot_o = pac_pkg::COORD_W'($signed(res));

endmodule

FILE: design/pac_datapath.sv
// ---------------------------------------------------------------------------
// pac_datapath
// Vertex registers, shared multiplier pair, shoelace accumulators,
// centroid divider and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pac_datapath #(
  parameter int COORD_BITS   = pac_pkg::DEF_COORD_BITS,
  parameter int MAX_VERTICES = pac_pkg::DEF_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pac_pkg::pac_cmd_t                   cmd_i,
  output pac_pkg::pac_status_t                status_o,
  input  logic signed [pac_pkg::COORD_W-1:0]  in_x_i,
  input  logic signed [pac_pkg::COORD_W-1:0]  in_y_i,
  input  logic                                in_last_i,
  output logic signed [pac_pkg::AREA_W-1:0]   res_area_o,
  output logic signed [pac_pkg::COORD_W-1:0]  res_cx_o,
  output logic signed [pac_pkg::COORD_W-1:0]  res_cy_o,
  output logic                                res_degen_o,
  output logic                                res_over_o
);

  localparam int CW    = pac_pkg::COORD_W;
  localparam int MA_W  = CW + 1;
  localparam int MB_W  = 2 * CW + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  function automatic logic signed [CW-1:0] sext(input logic [CW-1:0] v);
    sext = CW'($signed(v[COORD_BITS-1:0]));
  endfunction

  logic signed [CW-1:0]              cur_x_r, cur_y_r;
  logic                              last_r;
  logic signed [CW-1:0]              first_x_r, first_y_r;
  logic signed [CW-1:0]              prev_x_r, prev_y_r;
  logic [CNT_W-1:0]                  count_r;
  logic                              over_r;
  logic signed [pac_pkg::AREA_W-1:0] area_r;
  logic signed [pac_pkg::MOM_W-1:0]  mx_r, my_r;
  logic signed [MA_W-1:0]            sx_r, sy_r;
  logic signed [MB_W-1:0]            c_r;
  logic signed [P_W-1:0]             p0_r, p1_r;
  logic signed [CW-1:0]              cx_r, cy_r;

  logic signed [CW-1:0]   bx, by;
  logic signed [MA_W-1:0] op0a, op1a;
  logic signed [MB_W-1:0] op0b, op1b;
  logic signed [P_W-1:0]  prod0, prod1;
  logic                   degen;

  logic                             div_done;
  logic signed [CW-1:0]             div_q;
  logic signed [pac_pkg::MOM_W-1:0] div_num;

  assign bx = cmd_i.sel_close ? first_x_r : cur_x_r;
  assign by = cmd_i.sel_close ? first_y_r : cur_y_r;

  // phase A: ax*by and ay*bx; phase B: (ax+bx)*c and (ay+by)*c
  always_comb begin
    if (cmd_i.mul_a) begin
      op0a = MA_W'(prev_x_r);
      op0b = MB_W'(by);
      op1a = MA_W'(prev_y_r);
      op1b = MB_W'(bx);
    end else begin
      op0a = sx_r;
      op0b = c_r;
      op1a = sy_r;
      op1b = c_r;
    end
  end

  assign prod0 = P_W'(op0a) * P_W'(op0b);
  assign prod1 = P_W'(op1a) * P_W'(op1b);

  assign div_num = cmd_i.div_sel_y ? my_r : mx_r;

  pac_divider #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (area_r),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign degen = (count_r < CNT_W'(3)) || (area_r == '0);

  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      cur_x_r <= sext(in_x_i);
      cur_y_r <= sext(in_y_i);
      last_r  <= in_last_i;
    end
    if (cmd_i.mul_a) begin
      sx_r <= MA_W'(prev_x_r) + MA_W'(bx);
      sy_r <= MA_W'(prev_y_r) + MA_W'(by);
    end
    if (cmd_i.mul_a || cmd_i.mul_b) begin
      p0_r <= prod0;
      p1_r <= prod1;
    end
    if (cmd_i.cross_sub) begin
      c_r <= MB_W'(p0_r - p1_r);
    end
    if (div_done) begin
      if (cmd_i.div_sel_y) begin
        cy_r <= div_q;
      end else begin
        cx_r <= div_q;
      end
    end
    if (cmd_i.out_load) begin
      res_area_o  <= area_r;
      res_cx_o    <= degen ? '0 : cx_r;
      res_cy_o    <= degen ? '0 : cy_r;
      res_degen_o <= degen;
      res_over_o  <= over_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.out_load) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      count_r   <= '0;
      over_r    <= 1'b0;
      area_r    <= '0;
      mx_r      <= '0;
      my_r      <= '0;
    end else begin
      if (cmd_i.set_first) begin
        first_x_r <= cur_x_r;
        first_y_r <= cur_y_r;
      end
      if (cmd_i.set_first || cmd_i.upd_prev) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
        count_r  <= count_r + 1'b1;
      end
      if (cmd_i.set_over) begin
        over_r <= 1'b1;
      end
      if (cmd_i.mul_b) begin
        area_r <= area_r + pac_pkg::AREA_W'(c_r);
      end
      if (cmd_i.acc_m) begin
        mx_r <= mx_r + pac_pkg::MOM_W'(p0_r);
        my_r <= my_r + pac_pkg::MOM_W'(p1_r);
      end
    end
  end

  assign status_o.count_zero = (count_r == '0);
  assign status_o.count_full = (count_r >= CNT_W'(MAX_VERTICES));
  assign status_o.last       = last_r;
  assign status_o.div_done   = div_done;

endmodule

FILE: design/pac_ctrl.sv
// ---------------------------------------------------------------------------
// pac_ctrl
// Sequencer: vertex intake, edge multiply-accumulate steps, ring closing,
// the two centroid divides and the result handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_area_centroid_defines.svh"

module pac_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pac_pkg::pac_status_t  status_i,
  output pac_pkg::pac_cmd_t     cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECIDE = 11'b00000000010,
    S_MUL1   = 11'b00000000100,
    S_CROSS  = 11'b00000001000,
    S_MUL2   = 11'b00000010000,
    S_ACC    = 11'b00000100000,
    S_DSX    = 11'b00001000000,
    S_DWX    = 11'b00010000000,
    S_DSY    = 11'b00100000000,
    S_DWY    = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } pac_state_t;

  pac_state_t state_r, state_nxt;
  logic       close_r, close_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    close_nxt  = close_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (status_i.count_full) begin
          cmd_o.set_over = 1'b1;
          close_nxt      = 1'b1;
          state_nxt      = status_i.last ? S_MUL1 : S_IDLE;
        end else if (status_i.count_zero) begin
          cmd_o.set_first = 1'b1;
          close_nxt       = 1'b1;
          state_nxt       = status_i.last ? S_MUL1 : S_IDLE;
        end else begin
          close_nxt = 1'b0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul_a     = 1'b1;
        cmd_o.sel_close = close_r;
        state_nxt       = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.cross_sub = 1'b1;
        state_nxt       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_b = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_m = 1'b1;
        if (close_r) begin
          state_nxt = S_DSX;
        end else begin
          cmd_o.upd_prev = 1'b1;
          close_nxt      = 1'b1;
          state_nxt      = status_i.last ? S_MUL1 : S_IDLE;
        end
      end
      S_DSX: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = S_DWX;
      end
      S_DWX: begin
        if (status_i.div_done) begin
          state_nxt = S_DSY;
        end
      end
      S_DSY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_nxt       = S_DWY;
      end
      S_DWY: begin
        cmd_o.div_sel_y = 1'b1;
        if (status_i.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_o = out_valid_r;

  `PAC_ASSERT_NXT(a_accept_decide, clk, rst_n, in_valid_i && in_ready_o, state_r == S_DECIDE)
  `PAC_ASSERT_IMP(a_done_in_wait, clk, rst_n, status_i.div_done, state_r == S_DWX || state_r == S_DWY)
  `PAC_ASSERT_NXT(a_load_valid, clk, rst_n, cmd_o.out_load, out_valid_r)
  `PAC_ASSERT_NXT(a_div_no_done, clk, rst_n, cmd_o.div_start, !status_i.div_done)

endmodule

FILE: design/polygon_area_centroid.sv
// Interior vertex: decide, multiply, cross, multiply and accumulate steps from accept to the next ready;
// first vertex and dropped ones: decide only. Last vertex: its own edge if interior, then a closing edge,
// then two divides through one shared bit-serial divider, then the result register.
// Per-edge cost is set by the shared multiplier pair used twice per edge.
// Reset: synchronous active low; clears sequencer, accumulators and out valid.
// ---------------------------------------------------------------------------
// polygon_area_centroid
// Shoelace area and centroid of a vertex stream, one result per polygon.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_area_centroid #(
  parameter int COORD_BITS   = pac_pkg::DEF_COORD_BITS,
  parameter int MAX_VERTICES = pac_pkg::DEF_MAX_VERTICES
) (
  input  logic          clk,
  input  logic          rst_n,
  pac_vertex_if.sink    in_vtx,
  pac_result_if.source  out_res
);

  pac_pkg::pac_cmd_t    cmd;
  pac_pkg::pac_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  pac_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_vtx.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_res.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pac_datapath #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_x_i      (in_vtx.vertex_x),
    .in_y_i      (in_vtx.vertex_y),
    .in_last_i   (in_vtx.last_vertex),
    .res_area_o  (out_res.twice_area),
    .res_cx_o    (out_res.centroid_x),
    .res_cy_o    (out_res.centroid_y),
    .res_degen_o (out_res.degenerate),
    .res_over_o  (out_res.too_many)
  );

  assign in_vtx.ready  = in_ready;
  assign out_res.valid = out_valid;

endmodule

FILE: tb/polygon_area_centroid_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polygon_area_centroid_checker
// Watches the vertex and result channels, computes the shoelace area and
// rounded centroid of each polygon, and compares every result item with the
// oldest outstanding prediction. Reports failures and outstanding results.
// ---------------------------------------------------------------------------

module polygon_area_centroid_checker (
  input  logic   clk,
  input  logic   rst_n,
  pac_vertex_if  vtx,
  pac_result_if  res,
  output int     fail_count,
  output int     results_outstanding
);

  localparam int COORD_BITS   = pac_pkg::DEF_COORD_BITS;
  localparam int MAX_VERTICES = pac_pkg::DEF_MAX_VERTICES;

  typedef logic signed [pac_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [pac_pkg::AREA_W-1:0]  twice_area;
    logic signed [pac_pkg::COORD_W-1:0] centroid_x;
    logic signed [pac_pkg::COORD_W-1:0] centroid_y;
    logic                               degenerate;
    logic                               too_many;
  } polygon_result_t;

  polygon_result_t results_due[$];

  longint      first_x, first_y, prev_x, prev_y;
  longint      area_acc, mom_x_acc, mom_y_acc;
  int unsigned vertex_count;
  bit          vertices_dropped;
  int          mismatches;

  function automatic longint coord_value(input logic [pac_pkg::COORD_W-1:0] raw);
    coord_t v;
    v = $signed(raw << (pac_pkg::COORD_W - COORD_BITS)) >>> (pac_pkg::COORD_W - COORD_BITS);
    return longint'(v);
  endfunction

  function automatic void clear_polygon();
    first_x          = 0;
    first_y          = 0;
    prev_x           = 0;
    prev_y           = 0;
    area_acc         = 0;
    mom_x_acc        = 0;
    mom_y_acc        = 0;
    vertex_count     = 0;
    vertices_dropped = 1'b0;
  endfunction

  function automatic void add_side(input longint ax, input longint ay,
                                   input longint bx, input longint by);
    longint cp;
    cp        = ax * by - ay * bx;
    area_acc  += cp;
    mom_x_acc += (ax + bx) * cp;
    mom_y_acc += (ay + by) * cp;
  endfunction

  // moment / (3 * area), half away from zero, saturated to the coordinate range
  function automatic coord_t centroid_round(input longint moment, input longint area);
    bit                neg;
    longint unsigned   mag, div3, quo;
    longint            hi, lo, r;
    neg  = (moment < 0) != (area < 0);
    mag  = (moment < 0) ? -moment : moment;
    div3 = 3 * ((area < 0) ? -area : area);
    quo  = (2 * mag + div3) / (2 * div3);
    hi   = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo   = -hi - 1;
    if (neg) begin
      r = (quo > longint'(hi) + 1) ? lo : -longint'(quo);
    end else begin
      r = (quo > hi) ? hi : longint'(quo);
    end
    return coord_t'(r);
  endfunction

  function automatic void accumulate_vertex(input longint x, input longint y,
                                            input logic is_last);
    polygon_result_t r;
    if (vertex_count >= MAX_VERTICES) begin
      vertices_dropped = 1'b1;
    end else begin
      if (vertex_count == 0) begin
        first_x = x;
        first_y = y;
      end else begin
        add_side(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      vertex_count++;
    end
    if (is_last) begin
      if (vertex_count > 0) add_side(prev_x, prev_y, first_x, first_y);
      r.degenerate = (vertex_count < 3) || (area_acc == 0);
      r.twice_area = area_acc[pac_pkg::AREA_W-1:0];
      r.centroid_x = r.degenerate ? coord_t'(0) : centroid_round(mom_x_acc, area_acc);
      r.centroid_y = r.degenerate ? coord_t'(0) : centroid_round(mom_y_acc, area_acc);
      r.too_many   = vertices_dropped;
      results_due.push_back(r);
      clear_polygon();
    end
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    polygon_result_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      $display("%0t: result item with nothing expected, twice_area %0d", $time,
               res.twice_area);
      return;
    end
    want = results_due.pop_front();
    compare_field("twice_area", want.twice_area, res.twice_area);
    compare_field("centroid_x", want.centroid_x, res.centroid_x);
    compare_field("centroid_y", want.centroid_y, res.centroid_y);
    compare_field("degenerate", want.degenerate, res.degenerate);
    compare_field("too_many", want.too_many, res.too_many);
  endfunction

  initial begin
    clear_polygon();
    mismatches = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_polygon();
      results_due.delete();
    end else begin
      if (vtx.valid && vtx.ready) begin
        accumulate_vertex(coord_value(vtx.vertex_x), coord_value(vtx.vertex_y),
                          vtx.last_vertex);
      end
      if (res.valid && res.ready) check_result();
    end
    fail_count          <= mismatches;
    results_outstanding <= results_due.size();
  end

endmodule

FILE: tb/polygon_area_centroid_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polygon_area_centroid_tb
// Feeds polygons as vertex streams: directed corner cases, then random
// polygons of several shapes under varying backpressure and a long result
// stall. The checker predicts and compares; this module makes stimulus and
// gives the verdict.
// ---------------------------------------------------------------------------

module polygon_area_centroid_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 1700;

  typedef logic signed [pac_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum int {
    SHAPE_WIDE,
    SHAPE_CLUSTER,
    SHAPE_RECT,
    SHAPE_LINE,
    SHAPE_SPECK,
    SHAPE_BOWTIE
  } shape_t;

  logic   clk = 1'b0;
  logic   rst_n;
  int     fail_count;
  int     results_outstanding;
  int     tx_idle_pct;
  int     rx_idle_pct;
  bit     rx_hold_req = 1'b0;
  int     hold_n;
  int     stall_run = 0;
  int     items_sent = 0;
  point_t ring[$];

  pac_vertex_if in_vtx ();
  pac_result_if out_res ();

  always #(CLK_PERIOD / 2) clk = ~clk;

  polygon_area_centroid i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_vtx),
    .out_res (out_res)
  );

  polygon_area_centroid_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .vtx                 (in_vtx),
    .res                 (out_res),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic void add_point(input int x, input int y);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    ring.push_back(p);
  endfunction

  function automatic void random_polygon();
    int     n, pick, cx, cy, d, e, sx, sy;
    int     x0, y0, x1, y1;
    bit     flip;
    shape_t shape;
    ring.delete();
    pick = $urandom_range(99);
    if (pick < 6) n = $urandom_range(1, 2);
    else if (pick < 90) n = $urandom_range(3, 10);
    else n = $urandom_range(11, 48);
    shape = shape_t'($urandom_range(SHAPE_BOWTIE));
    case (shape)
      SHAPE_WIDE: begin
        repeat (n) add_point(rand_coord(), rand_coord());
      end
      SHAPE_CLUSTER, SHAPE_SPECK: begin
        d  = (shape == SHAPE_CLUSTER) ? 50 : 2;
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        repeat (n) begin
          add_point(cx + int'($urandom_range(2 * d)) - d,
                    cy + int'($urandom_range(2 * d)) - d);
        end
      end
      SHAPE_RECT: begin
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = rand_coord();
        y1 = rand_coord();
        add_point(x0, y0);
        add_point(x1, y0);
        add_point(x1, y1);
        add_point(x0, y1);
      end
      SHAPE_LINE: begin
        cx = int'($urandom_range(40000)) - 20000;
        cy = int'($urandom_range(40000)) - 20000;
        sx = int'($urandom_range(400)) - 200;
        sy = int'($urandom_range(400)) - 200;
        for (int k = 0; k < n; k++) add_point(cx + k * sx, cy + k * sy);
      end
      SHAPE_BOWTIE: begin
        // crossing quad whose lobes nearly cancel: centroid far outside
        d    = $urandom_range(1000, 30000);
        e    = $urandom_range(0, 3);
        flip = $urandom_range(1);
        cx   = int'($urandom_range(65535 - d)) - 32768;
        cy   = int'($urandom_range(65535 - d)) - 32768;
        add_point(flip ? cx + d : cx, cy);
        add_point(flip ? cx : cx + d, cy + d);
        add_point(flip ? cx : cx + d, cy + e);
        add_point(flip ? cx + d : cx, cy + d);
      end
      default: add_point(0, 0);
    endcase
  endfunction

  task automatic push_vertex(input point_t p, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_vtx.valid <= 1'b0;
      @(posedge clk);
    end
    in_vtx.valid       <= 1'b1;
    in_vtx.vertex_x    <= p.x;
    in_vtx.vertex_y    <= p.y;
    in_vtx.last_vertex <= is_last;
    @(posedge clk);
    while (!in_vtx.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ring();
    foreach (ring[i]) push_vertex(ring[i], i == ring.size() - 1);
  endtask

  task automatic await_results();
    in_vtx.valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      random_polygon();
      send_ring();
    end
  endtask

  task automatic directed_polygons();
    ring.delete();
    add_point(5, -7);
    send_ring();
    ring.delete();
    add_point(-32768, 32767);
    add_point(32767, -32768);
    send_ring();
    // collinear, zero area
    ring.delete();
    add_point(-3, -3);
    add_point(0, 0);
    add_point(3, 3);
    send_ring();
    // centroid exactly on a half, both signs
    ring.delete();
    add_point(0, 0);
    add_point(1, 0);
    add_point(1, 1);
    add_point(0, 1);
    send_ring();
    ring.delete();
    add_point(-1, 0);
    add_point(-1, 1);
    add_point(0, 1);
    add_point(0, 0);
    send_ring();
    ring.delete();
    add_point(-32768, -32768);
    add_point(32767, -32768);
    add_point(32767, 32767);
    send_ring();
    // centroid saturation, low then high
    ring.delete();
    add_point(0, 0);
    add_point(30000, 30000);
    add_point(30000, 1);
    add_point(0, 30000);
    send_ring();
    ring.delete();
    add_point(30000, 0);
    add_point(0, 30000);
    add_point(0, 1);
    add_point(30000, 30000);
    send_ring();
  endtask

  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_res.ready <= 1'b0;
        for (hold_n = 0; hold_n < RX_HOLD_CYCLES; hold_n++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_vtx.valid && in_vtx.ready) || (out_res.valid && out_res.ready)) begin
      stall_run <= 0;
    end else if (stall_run >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_vtx.valid       = 1'b0;
    in_vtx.vertex_x    = '0;
    in_vtx.vertex_y    = '0;
    in_vtx.last_vertex = 1'b0;
    tx_idle_pct        = 12;
    rx_idle_pct        = 53;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_polygons();
    run_random(RANDOM_ITEMS / 3);

    // stall results long enough for the block to back up its input
    rx_hold_req = 1'b1;
    repeat (12) begin
      random_polygon();
      send_ring();
    end
    await_results();

    tx_idle_pct = 53;
    rx_idle_pct = 12;
    run_random(RANDOM_ITEMS / 3);
    await_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_ITEMS / 3);

    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/pac_pkg.sv
design/pac_vertex_if.sv
design/pac_result_if.sv
design/pac_divider.sv
design/pac_datapath.sv
design/pac_ctrl.sv
design/polygon_area_centroid.sv
tb/polygon_area_centroid_checker.sv
tb/polygon_area_centroid_tb.sv
